### hw/rtl/mbts_pkg.sv
// Shared types, codes and constants of the memory bus test sequencer.
package mbts_pkg;

    typedef enum logic
    {
        OP_START     = 1'b0,
        OP_READ_DATA = 1'b1
    } mbts_op_t;

    typedef enum logic [1:0]
    {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_FINISH = 2'd2
    } mbts_req_t;

    typedef enum logic [1:0]
    {
        STATUS_PASS        = 2'd0,
        STATUS_DATA_FAULT  = 2'd1,
        STATUS_ADDR_FAULT  = 2'd2
    } mbts_status_t;

    typedef enum logic [5:0]
    {
        PH_IDLE  = 6'b000001,
        PH_DBUS  = 6'b000010,
        PH_FILL  = 6'b000100,
        PH_CHECK = 6'b001000,
        PH_WALK  = 6'b010000,
        PH_DONE  = 6'b100000
    } mbts_phase_t;

    typedef struct packed
    {
        mbts_op_t    operation;
        logic [31:0] read_data;
    } mbts_item_t;

    typedef struct packed
    {
        mbts_req_t    request;
        logic [31:0]  address;
        logic [31:0]  write_data;
        mbts_status_t status;
        logic [31:0]  fault_pattern;
        logic         last;
    } mbts_result_t;

    typedef struct packed
    {
        mbts_phase_t phase;
        logic [31:0] outer_offset;
        logic [31:0] inner_offset;
    } mbts_ctrl_t;

    localparam int MAX_RESULTS  = 4;
    localparam int RESULT_IDX_W = 2;
    localparam int RESULT_CNT_W = 3;
    localparam int QUEUE_DEPTH  = 8;
    localparam int QUEUE_PTR_W  = 3;
    localparam int QUEUE_CNT_W  = 4;

    localparam logic [31:0] FILL_WORD    = 32'h0A0A_0A0A;
    localparam logic [31:0] RESET_BASE   = 32'h0010_0000;
    localparam logic [31:0] FIRST_OFFSET = 32'd4;
    localparam logic [31:0] MAX_OFFSET   = 32'h8000_0000;

endpackage

### hw/rtl/mbts_step.sv
// Combinational next-step logic: decodes one registered item into results and next state.
module mbts_step
    import mbts_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  mbts_item_t                         item,
    input  mbts_ctrl_t                         ctrl,
    input  logic [DATA_WIDTH-1:0]              walk_pattern,
    input  logic [31:0]                        base_address,
    input  logic [31:0]                        address_limit,
    output mbts_result_t [MAX_RESULTS-1:0]     results,
    output logic [RESULT_CNT_W-1:0]            result_count,
    output mbts_ctrl_t                         ctrl_next,
    output logic [DATA_WIDTH-1:0]              walk_pattern_next
);

    // An offset is usable when base plus offset stays below the limit, without wrap-around.
    function automatic logic in_range(input logic [31:0] base, input logic [31:0] limit,
                                      input logic [31:0] off);
        logic [32:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        return (off != 32'd0) && (off <= MAX_OFFSET) && (sum < {1'b0, limit});
    endfunction

    // Next power-of-two offset, or zero when there is none.
    function automatic logic [31:0] next_offset(input logic [31:0] base,
                                                input logic [31:0] limit,
                                                input logic [31:0] off);
        logic [31:0] cand;
        cand = {off[30:0], 1'b0};
        return (!off[31] && in_range(base, limit, cand)) ? cand : 32'd0;
    endfunction

    function automatic mbts_result_t make_result(input mbts_req_t req,
                                                 input logic [31:0] addr,
                                                 input logic [31:0] data,
                                                 input mbts_status_t st,
                                                 input logic [31:0] pat);
        mbts_result_t r;
        r.request       = req;
        r.address       = addr;
        r.write_data    = data;
        r.status        = st;
        r.fault_pattern = pat;
        r.last          = 1'b0;
        return r;
    endfunction

    logic [DATA_WIDTH-1:0] rd_w;
    logic [DATA_WIDTH-1:0] fill_w;
    logic [DATA_WIDTH-1:0] walk_shift;
    logic [31:0]           fill32;
    logic [31:0]           fill_inv32;
    logic [31:0]           walk32;
    logic [31:0]           walk_shift32;
    logic [31:0]           first_off;
    logic [31:0]           next_first;
    logic [31:0]           next_outer;
    logic [31:0]           next_inner;
    logic [31:0]           walk_q;
    logic [31:0]           fill_o;
    logic [31:0]           wf_o;
    logic [31:0]           wf_q;
    logic                  fill_ok;
    logic                  walk_ok;

    // Data words are DATA_WIDTH bits; the ports carry 32.
    assign rd_w         = DATA_WIDTH'(item.read_data);
    assign fill_w       = DATA_WIDTH'(FILL_WORD);
    assign walk_shift   = walk_pattern << 1;
    assign fill32       = 32'(fill_w);
    assign fill_inv32   = 32'(~fill_w);
    assign walk32       = 32'(walk_pattern);
    assign walk_shift32 = 32'(walk_shift);
    assign fill_ok      = (rd_w == fill_w);
    assign walk_ok      = (rd_w == walk_pattern);

    assign first_off  = in_range(base_address, address_limit, FIRST_OFFSET) ?
                        FIRST_OFFSET : 32'd0;
    assign next_first = next_offset(base_address, address_limit, first_off);
    assign next_outer = next_offset(base_address, address_limit, ctrl.outer_offset);
    assign next_inner = next_offset(base_address, address_limit, ctrl.inner_offset);

    // In the walk phase the offset under test is skipped.
    assign walk_q = ((next_inner != 32'd0) && (next_inner == ctrl.outer_offset)) ?
                    next_offset(base_address, address_limit, next_inner) : next_inner;

    assign fill_o = (ctrl.outer_offset == 32'd0) ? first_off : next_outer;

    // Offset inverted next, and the first other offset to check against it.
    assign wf_o = (ctrl.phase == PH_WALK) ? next_outer : first_off;
    assign wf_q = (first_off == wf_o) ? next_first : first_off;

    always_comb
    begin
        logic [RESULT_CNT_W-1:0] cnt;
        logic [RESULT_IDX_W-1:0] last_idx;
        logic                    do_walk;

        results           = '0;
        cnt               = '0;
        do_walk           = 1'b0;
        ctrl_next         = ctrl;
        walk_pattern_next = walk_pattern;

        if (item.operation == OP_START)
        begin
            walk_pattern_next = DATA_WIDTH'(1);
            results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address, 32'd1,
                                                         STATUS_PASS, 32'd0);
            cnt = cnt + 1'b1;
            results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_READ, base_address, 32'd0,
                                                         STATUS_PASS, 32'd0);
            cnt = cnt + 1'b1;
            ctrl_next.phase = PH_DBUS;
        end
        else
        begin
            unique case (ctrl.phase)
                PH_DBUS:
                begin
                    if (!walk_ok)
                    begin
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_FINISH, 32'd0, 32'd0,
                                                                     STATUS_DATA_FAULT, walk32);
                        cnt = cnt + 1'b1;
                        ctrl_next.phase = PH_DONE;
                    end
                    else
                    begin
                        walk_pattern_next = walk_shift;
                        if (walk_shift != '0)
                        begin
                            results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address,
                                walk_shift32, STATUS_PASS, 32'd0);
                            cnt = cnt + 1'b1;
                        end
                        else
                        begin
                            ctrl_next.outer_offset = 32'd0;
                            results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address,
                                fill32, STATUS_PASS, 32'd0);
                            cnt = cnt + 1'b1;
                            ctrl_next.phase = PH_FILL;
                        end
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_READ, base_address,
                                                                     32'd0, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                    end
                end
                PH_FILL:
                begin
                    if (!fill_ok)
                    begin
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_FINISH, 32'd0, 32'd0,
                                                                     STATUS_ADDR_FAULT, 32'd0);
                        cnt = cnt + 1'b1;
                        ctrl_next.phase = PH_DONE;
                    end
                    else if (fill_o != 32'd0)
                    begin
                        ctrl_next.outer_offset = fill_o;
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE,
                            base_address + fill_o, fill32, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_READ,
                            base_address + fill_o, 32'd0, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address,
                                                                     fill_inv32, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                        if (first_off != 32'd0)
                        begin
                            ctrl_next.outer_offset = first_off;
                            results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_READ,
                                base_address + first_off, 32'd0, STATUS_PASS, 32'd0);
                            cnt = cnt + 1'b1;
                            ctrl_next.phase = PH_CHECK;
                        end
                        else
                        begin
                            results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address,
                                fill32, STATUS_PASS, 32'd0);
                            cnt = cnt + 1'b1;
                            do_walk = 1'b1;
                        end
                    end
                end
                PH_CHECK:
                begin
                    if (!fill_ok)
                    begin
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_FINISH, 32'd0, 32'd0,
                                                                     STATUS_ADDR_FAULT, 32'd0);
                        cnt = cnt + 1'b1;
                        ctrl_next.phase = PH_DONE;
                    end
                    else if (next_outer != 32'd0)
                    begin
                        ctrl_next.outer_offset = next_outer;
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_READ,
                            base_address + next_outer, 32'd0, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address,
                                                                     fill32, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                        do_walk = 1'b1;
                    end
                end
                PH_WALK:
                begin
                    if (!fill_ok)
                    begin
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_FINISH, 32'd0, 32'd0,
                                                                     STATUS_ADDR_FAULT, 32'd0);
                        cnt = cnt + 1'b1;
                        ctrl_next.phase = PH_DONE;
                    end
                    else if (walk_q != 32'd0)
                    begin
                        ctrl_next.inner_offset = walk_q;
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_READ,
                            base_address + walk_q, 32'd0, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                    end
                    else
                    begin
                        results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE,
                            base_address + ctrl.outer_offset, fill32, STATUS_PASS, 32'd0);
                        cnt = cnt + 1'b1;
                        do_walk = 1'b1;
                    end
                end
                PH_IDLE, PH_DONE:
                begin
                    // Returned data with no test running is dropped.
                end
                default:
                begin
                end
            endcase
        end

        // Start inverting the next offset. When no other offset exists to check,
        // the lone offset is restored and the test passes.
        if (do_walk)
        begin
            if (wf_o == 32'd0)
            begin
                results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_FINISH, 32'd0, 32'd0,
                                                             STATUS_PASS, 32'd0);
                cnt = cnt + 1'b1;
                ctrl_next.phase = PH_DONE;
            end
            else
            begin
                ctrl_next.outer_offset = wf_o;
                results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address + wf_o,
                                                             fill_inv32, STATUS_PASS, 32'd0);
                cnt = cnt + 1'b1;
                if (wf_q != 32'd0)
                begin
                    ctrl_next.inner_offset = wf_q;
                    results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_READ, base_address + wf_q,
                                                                 32'd0, STATUS_PASS, 32'd0);
                    cnt = cnt + 1'b1;
                    ctrl_next.phase = PH_WALK;
                end
                else
                begin
                    results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_WRITE, base_address + wf_o,
                                                                 fill32, STATUS_PASS, 32'd0);
                    cnt = cnt + 1'b1;
                    results[cnt[RESULT_IDX_W-1:0]] = make_result(REQ_FINISH, 32'd0, 32'd0,
                                                                 STATUS_PASS, 32'd0);
                    cnt = cnt + 1'b1;
                    ctrl_next.phase = PH_DONE;
                end
            end
        end

        last_idx = cnt[RESULT_IDX_W-1:0] - 1'b1;
        if (cnt != '0)
        begin
            results[last_idx].last = 1'b1;
        end

        result_count = cnt;
    end

endmodule

### hw/rtl/mbts_queue.sv
// Result queue: takes up to four results per cycle and hands them out one per transfer.
module mbts_queue
    import mbts_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [RESULT_CNT_W-1:0]        push_count,
    input  mbts_result_t [MAX_RESULTS-1:0] push_data,
    output logic                           room,
    output logic                           out_valid,
    input  logic                           out_stall,
    output mbts_result_t                   out_data
);

    mbts_result_t               entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]     count_reg;
    logic [QUEUE_CNT_W-1:0]     count_next;
    logic                       pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - MAX_RESULTS));

    assign wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
    assign count_next  = count_reg + QUEUE_CNT_W'(push_count) - QUEUE_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (RESULT_CNT_W'(i) < push_count)
            begin
                entries_reg[wr_ptr_reg + QUEUE_PTR_W'(i)] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/memory_bus_test_sequencer_unit.sv
// Top level of the memory bus test sequencer: item register, sequencer state and result queue.
//
// The sequencer runs a memory bus test by issuing write and read requests as results and
// checking each word that is sent back as an item. A start item begins (or restarts) the
// test: a walking-one data bus test at the base address, followed by an address bus test
// over the power-of-two offsets from four upwards whose addresses stay below the limit.
// A finish result carries the verdict (pass, data bus fault with the failing pattern, or
// address bus fault). Read data that arrives while no test is running is dropped. Each
// accepted item is held in an input register, where short decode logic produces up to
// four results and the next sequencer state in the same cycle; the results enter an
// eight-entry queue at the clock edge that moves the item on, and are offered from then on.
// Input transfers are taken every cycle as long as the queue has room for four more
// results, so the sustained rate is set by the queue's single output port: an item causes
// one or two results for almost every step of the test and at most four. The base address
// and limit registers are written through the configuration port and should only change
// while the block is idle. DATA_WIDTH sets how many low bits of each word are tested,
// from 8 to 32, as the ports carry 32-bit words.
module memory_bus_test_sequencer_unit
    import mbts_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  mbts_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output mbts_result_t result,
    input  logic         cfg_write,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic CFG_BASE_ADDRESS  = 1'b0;
    localparam logic CFG_ADDRESS_LIMIT = 1'b1;

    logic                           item_valid_reg;
    logic                           item_valid_next;
    mbts_item_t                     item_reg;
    logic                           item_take;
    logic                           advance;
    logic                           room;

    mbts_ctrl_t                     ctrl_reg;
    mbts_ctrl_t                     ctrl_next;
    logic [DATA_WIDTH-1:0]          walk_pattern_reg;
    logic [DATA_WIDTH-1:0]          walk_pattern_next;
    logic [31:0]                    base_address_reg;
    logic [31:0]                    address_limit_reg;

    mbts_result_t [MAX_RESULTS-1:0] step_results;
    logic [RESULT_CNT_W-1:0]        step_count;
    logic [RESULT_CNT_W-1:0]        push_count;

    // The item register moves on whenever the queue can hold the worst-case four
    // results, so a new transfer is taken in the same cycle.
    assign advance         = item_valid_reg && room;
    assign item_stall      = item_valid_reg && !room;
    assign item_take       = item_valid && !item_stall;
    assign item_valid_next = item_take || (item_valid_reg && !advance);
    assign push_count      = advance ? step_count : '0;

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg         <= 1'b0;
            ctrl_reg.phase         <= PH_IDLE;
            ctrl_reg.outer_offset  <= FIRST_OFFSET;
            ctrl_reg.inner_offset  <= FIRST_OFFSET;
            walk_pattern_reg       <= DATA_WIDTH'(1);
            base_address_reg       <= RESET_BASE;
            address_limit_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (advance)
            begin
                ctrl_reg         <= ctrl_next;
                walk_pattern_reg <= walk_pattern_next;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_BASE_ADDRESS:  base_address_reg  <= cfg_data;
                    CFG_ADDRESS_LIMIT: address_limit_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    mbts_step #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
        .item              (item_reg),
        .ctrl              (ctrl_reg),
        .walk_pattern      (walk_pattern_reg),
        .base_address      (base_address_reg),
        .address_limit     (address_limit_reg),
        .results           (step_results),
        .result_count      (step_count),
        .ctrl_next         (ctrl_next),
        .walk_pattern_next (walk_pattern_next)
    );

    mbts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_data  (step_results),
        .room       (room),
        .out_valid  (result_valid),
        .out_stall  (result_stall),
        .out_data   (result)
    );

endmodule

### test/tb_memory_bus_test_sequencer_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the memory bus test sequencer, driven from a planned item queue.
module tb_memory_bus_test_sequencer_unit;
    import mbts_pkg::*;

    // The block is built for 32-bit words here. The predictor masks with the same width, so
    // a change here follows through to every comparison.
    localparam int DATA_WIDTH = 32;
    localparam logic [63:0] DATA_MASK = (DATA_WIDTH >= 64) ? {64{1'b1}} :
                                        ((64'd1 << DATA_WIDTH) - 64'd1);
    localparam logic [63:0] WORD_P     = {32'd0, FILL_WORD} & DATA_MASK;
    localparam logic [63:0] WORD_NOT_P = ~{32'd0, FILL_WORD} & DATA_MASK;

    // Register indexes of the configuration port.
    localparam logic CFG_BASE_ADDRESS  = 1'b0;
    localparam logic CFG_ADDRESS_LIMIT = 1'b1;

    // Cycles allowed after the last expected result for work that produces nothing, such as
    // read data that arrives while no test is running.
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    // Sequencer state as the predictor keeps it, together with its copy of the registers.
    typedef struct packed
    {
        mbts_phase_t phase;
        logic [63:0] pattern;
        logic [31:0] outer_off;
        logic [31:0] inner_off;
        logic [31:0] base;
        logic [31:0] limit;
    } seq_state_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_stall;
    mbts_item_t   item         = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    mbts_result_t result;
    logic         cfg_write    = 1'b0;
    logic         cfg_index    = 1'b0;
    logic [31:0]  cfg_data     = '0;

    // Two copies of the sequencer state: one follows the items as they are planned, so that
    // the planner knows which word a healthy memory would return; the other follows the
    // items as the block accepts them and produces the expected requests.
    seq_state_t plan_state;
    seq_state_t check_state;

    // Image of the tested memory: slot 0 is the base word, slot k the word at offset 2^(k+1).
    logic [31:0] memory_image [0:31];
    bit          read_outstanding = 1'b0;
    logic [31:0] outstanding_addr = '0;
    int          items_planned    = 0;

    mbts_item_t   queued_items[$];
    mbts_result_t awaited_requests[$];

    mbts_result_t [MAX_RESULTS-1:0] predicted;
    int           predicted_count;
    mbts_result_t oldest_request;
    int           error_count = 0;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    bit sender_paused   = 1'b0;
    bit hold_trigger    = 1'b0;
    bit hold_seen       = 1'b0;
    int hold_remaining  = 0;

    memory_bus_test_sequencer_unit #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // An offset is tested while it is a power of two no larger than 2^31 and the base plus
    // the offset, taken without wrap-around, stays below the limit.
    function automatic bit offset_in_range(seq_state_t st, logic [63:0] off);
        return off != 64'd0 && off <= {32'd0, MAX_OFFSET} &&
               ({32'd0, st.base} + off) < {32'd0, st.limit};
    endfunction

    // Zero stands for "no further offset" in both of these.
    function automatic logic [31:0] first_offset(seq_state_t st);
        return offset_in_range(st, {32'd0, FIRST_OFFSET}) ? FIRST_OFFSET : 32'd0;
    endfunction

    function automatic logic [31:0] next_offset(seq_state_t st, logic [31:0] off);
        logic [63:0] doubled;
        doubled = {32'd0, off} << 1;
        return offset_in_range(st, doubled) ? doubled[31:0] : 32'd0;
    endfunction

    function automatic mbts_result_t bus_request(seq_state_t st, mbts_req_t req,
                                                 logic [31:0] off, logic [63:0] data,
                                                 mbts_status_t stat, logic [63:0] pat);
        mbts_result_t r;
        r.request       = req;
        r.address       = (req == REQ_FINISH) ? 32'd0 : st.base + off;
        r.write_data    = data[31:0];
        r.status        = stat;
        r.fault_pattern = pat[31:0];
        r.last          = 1'b0;
        return r;
    endfunction

    // Advances the sequencer by one item and returns the memory requests it issues.
    function automatic void step_sequencer(inout seq_state_t st, input mbts_item_t it,
                                           output mbts_result_t [MAX_RESULTS-1:0] reqs,
                                           output int count);
        logic [63:0] rd;
        logic [31:0] off;
        logic [31:0] walk_off;
        bit          walking;
        bit          parked;
        count    = 0;
        reqs     = '0;
        walking  = 1'b0;
        walk_off = '0;
        rd       = {32'd0, it.read_data} & DATA_MASK;
        if (it.operation == OP_START)
        begin
            // A start always begins afresh, even in the middle of a test.
            st.pattern = 64'd1;
            reqs[count] = bus_request(st, REQ_WRITE, 32'd0, 64'd1, STATUS_PASS, 64'd0);
            count++;
            reqs[count] = bus_request(st, REQ_READ, 32'd0, 64'd0, STATUS_PASS, 64'd0);
            count++;
            st.phase = PH_DBUS;
        end
        else if (st.phase == PH_DBUS)
        begin
            if (rd != st.pattern)
            begin
                reqs[count] = bus_request(st, REQ_FINISH, 32'd0, 64'd0, STATUS_DATA_FAULT,
                                          st.pattern);
                count++;
                st.phase = PH_DONE;
            end
            else
            begin
                st.pattern = (st.pattern << 1) & DATA_MASK;
                if (st.pattern != 64'd0)
                begin
                    reqs[count] = bus_request(st, REQ_WRITE, 32'd0, st.pattern, STATUS_PASS,
                                              64'd0);
                    count++;
                end
                else
                begin
                    st.outer_off = 32'd0;
                    reqs[count] = bus_request(st, REQ_WRITE, 32'd0, WORD_P, STATUS_PASS, 64'd0);
                    count++;
                    st.phase = PH_FILL;
                end
                reqs[count] = bus_request(st, REQ_READ, 32'd0, 64'd0, STATUS_PASS, 64'd0);
                count++;
            end
        end
        else if (st.phase == PH_FILL || st.phase == PH_CHECK || st.phase == PH_WALK)
        begin
            if (rd != WORD_P)
            begin
                reqs[count] = bus_request(st, REQ_FINISH, 32'd0, 64'd0, STATUS_ADDR_FAULT,
                                          64'd0);
                count++;
                st.phase = PH_DONE;
            end
            else if (st.phase == PH_FILL)
            begin
                off = (st.outer_off == 32'd0) ? first_offset(st) : next_offset(st, st.outer_off);
                if (off != 32'd0)
                begin
                    st.outer_off = off;
                    reqs[count] = bus_request(st, REQ_WRITE, off, WORD_P, STATUS_PASS, 64'd0);
                    count++;
                    reqs[count] = bus_request(st, REQ_READ, off, 64'd0, STATUS_PASS, 64'd0);
                    count++;
                end
                else
                begin
                    reqs[count] = bus_request(st, REQ_WRITE, 32'd0, WORD_NOT_P, STATUS_PASS,
                                              64'd0);
                    count++;
                    off = first_offset(st);
                    if (off != 32'd0)
                    begin
                        st.outer_off = off;
                        reqs[count] = bus_request(st, REQ_READ, off, 64'd0, STATUS_PASS, 64'd0);
                        count++;
                        st.phase = PH_CHECK;
                    end
                    else
                    begin
                        reqs[count] = bus_request(st, REQ_WRITE, 32'd0, WORD_P, STATUS_PASS,
                                                  64'd0);
                        count++;
                        walking  = 1'b1;
                        walk_off = first_offset(st);
                    end
                end
            end
            else if (st.phase == PH_CHECK)
            begin
                off = next_offset(st, st.outer_off);
                if (off != 32'd0)
                begin
                    st.outer_off = off;
                    reqs[count] = bus_request(st, REQ_READ, off, 64'd0, STATUS_PASS, 64'd0);
                    count++;
                end
                else
                begin
                    reqs[count] = bus_request(st, REQ_WRITE, 32'd0, WORD_P, STATUS_PASS, 64'd0);
                    count++;
                    walking  = 1'b1;
                    walk_off = first_offset(st);
                end
            end
            else
            begin
                // The inverted offset itself is skipped while the others are checked.
                off = next_offset(st, st.inner_off);
                if (off != 32'd0 && off == st.outer_off)
                    off = next_offset(st, off);
                if (off != 32'd0)
                begin
                    st.inner_off = off;
                    reqs[count] = bus_request(st, REQ_READ, off, 64'd0, STATUS_PASS, 64'd0);
                    count++;
                end
                else
                begin
                    reqs[count] = bus_request(st, REQ_WRITE, st.outer_off, WORD_P, STATUS_PASS,
                                              64'd0);
                    count++;
                    walking  = 1'b1;
                    walk_off = next_offset(st, st.outer_off);
                end
            end
        end
        if (walking)
        begin
            // Invert each remaining offset in turn until one has another offset to check;
            // with a single offset there is nothing to read and the test passes.
            parked = 1'b0;
            while (walk_off != 32'd0 && !parked)
            begin
                st.outer_off = walk_off;
                reqs[count] = bus_request(st, REQ_WRITE, walk_off, WORD_NOT_P, STATUS_PASS,
                                          64'd0);
                count++;
                off = first_offset(st);
                if (off == walk_off)
                    off = next_offset(st, off);
                if (off != 32'd0)
                begin
                    st.inner_off = off;
                    reqs[count] = bus_request(st, REQ_READ, off, 64'd0, STATUS_PASS, 64'd0);
                    count++;
                    st.phase = PH_WALK;
                    parked   = 1'b1;
                end
                else
                begin
                    reqs[count] = bus_request(st, REQ_WRITE, walk_off, WORD_P, STATUS_PASS,
                                              64'd0);
                    count++;
                    walk_off = next_offset(st, walk_off);
                end
            end
            if (!parked)
            begin
                reqs[count] = bus_request(st, REQ_FINISH, 32'd0, 64'd0, STATUS_PASS, 64'd0);
                count++;
                st.phase = PH_DONE;
            end
        end
        if (count > 0)
            reqs[count - 1].last = 1'b1;
    endfunction

    function automatic int word_slot(logic [31:0] addr);
        logic [31:0] off;
        off = addr - plan_state.base;
        return (off == 32'd0) ? 0 : $clog2(off) - 1;
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h", $time, field, want,
                     got);
            error_count++;
        end
    endfunction

    // Queues one item and moves the planning copy of the sequencer and the memory image on.
    task automatic plan_item(mbts_op_t op, logic [31:0] data);
        mbts_item_t                     it;
        mbts_result_t [MAX_RESULTS-1:0] reqs;
        int                             n;
        int                             i;
        it.operation = op;
        it.read_data = data;
        queued_items.push_back(it);
        items_planned++;
        step_sequencer(plan_state, it, reqs, n);
        for (i = 0; i < n; i++)
        begin
            if (reqs[i].request == REQ_WRITE)
                memory_image[word_slot(reqs[i].address)] = reqs[i].write_data;
        end
        // Every step with requests ends in a read or a finish.
        if (n > 0)
        begin
            read_outstanding = (reqs[n - 1].request == REQ_READ);
            outstanding_addr = reqs[n - 1].address;
        end
    endtask

    // Answers the outstanding read as a healthy memory would, or now and then with a
    // corrupted word: one flipped bit, a random mask or every bit inverted.
    task automatic answer_read(int fault_permille);
        logic [31:0] word;
        logic [31:0] flip;
        word = memory_image[word_slot(outstanding_addr)];
        if ($urandom_range(999) < fault_permille)
        begin
            case ($urandom_range(2))
                0:       flip = 32'd1 << $urandom_range(31);
                1:       flip = $urandom;
                default: flip = 32'hFFFF_FFFF;
            endcase
            if (flip == 32'd0)
                flip = 32'd1;
            word = word ^ flip;
        end
        plan_item(OP_READ_DATA, word);
    endtask

    // One complete test: a start, then answers until the test finishes. Past the read budget
    // a fault is forced so that the test always ends.
    task automatic run_test(int read_budget, int fault_permille, int restart_pct);
        int reads;
        reads = 0;
        plan_item(OP_START, $urandom);
        while (read_outstanding)
        begin
            if ($urandom_range(99) < restart_pct)
                plan_item(OP_START, $urandom);
            else if (reads >= read_budget)
                answer_read(1000);
            else
                answer_read(fault_permille);
            reads++;
        end
        // Stray read data after the finish must be dropped.
        if ($urandom_range(99) < 40)
            plan_item(OP_READ_DATA, $urandom);
    endtask

    task automatic run_random_tests(int item_goal, int read_budget, int fault_permille,
                                    int restart_pct);
        int goal;
        goal = items_planned + item_goal;
        while (items_planned < goal)
            run_test(read_budget, fault_permille, restart_pct);
    endtask

    // Waits until every item has been transferred and every expected request has arrived,
    // then gives the block time to finish any work that produces nothing.
    task automatic wait_idle();
        while (queued_items.size() != 0 || item_valid || awaited_requests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_BASE_ADDRESS)
        begin
            plan_state.base  = value;
            check_state.base = value;
        end
        else
        begin
            plan_state.limit  = value;
            check_state.limit = value;
        end
    endtask

    task automatic configure(logic [31:0] base, logic [31:0] limit);
        write_register(CFG_BASE_ADDRESS, base);
        write_register(CFG_ADDRESS_LIMIT, limit);
    endtask

    task automatic set_idling(int send_pct, int stall_pct);
        @(posedge clk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    // Sender. The offered item is held while the block stalls; when it is transferred the
    // expected requests are worked out, and the next queued item is offered unless the
    // sender idles or has been paused.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!(item_valid && item_stall))
        begin
            if (item_valid)
            begin
                step_sequencer(check_state, item, predicted, predicted_count);
                for (int k = 0; k < predicted_count; k++)
                    awaited_requests.push_back(predicted[k]);
            end
            if (queued_items.size() != 0 && !sender_paused &&
                $urandom_range(99) >= send_idle_pct)
            begin
                item       <= queued_items.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here so that the stimulus process only has to ask.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seen      <= 1'b0;
            hold_remaining <= 0;
        end
        else if (hold_trigger != hold_seen)
        begin
            hold_seen      <= hold_trigger;
            hold_remaining <= HOLD_OFF_CYCLES;
        end
        else if (hold_remaining != 0)
            hold_remaining <= hold_remaining - 1;
    end

    // Receiver. Each transferred result is checked field by field against the oldest
    // expected request; a result with nothing expected is a failure of its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_requests.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0d at 0x%08h",
                             $time, result.request, result.address);
                    error_count++;
                end
                else
                begin
                    oldest_request = awaited_requests.pop_front();
                    compare_field("request", 32'(oldest_request.request),
                                  32'(result.request));
                    compare_field("address", oldest_request.address, result.address);
                    compare_field("write_data", oldest_request.write_data, result.write_data);
                    compare_field("status", 32'(oldest_request.status), 32'(result.status));
                    compare_field("fault_pattern", oldest_request.fault_pattern,
                                  result.fault_pattern);
                    compare_field("last", 32'(oldest_request.last), 32'(result.last));
                end
            end
            result_stall <= (hold_remaining != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        int pause_point;
        check_state = '{PH_IDLE, 64'd1, FIRST_OFFSET, FIRST_OFFSET, RESET_BASE, 32'd0};
        plan_state  = check_state;
        for (int s = 0; s < 32; s++)
            memory_image[s] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items with the registers at their reset values, where no offset is in
        // range. Read data while idle is dropped, a wrong first word is a data bus fault on
        // the first pattern, read data after the finish is dropped, and a start in the
        // middle of the data bus test begins it again.
        plan_item(OP_READ_DATA, 32'hFFFF_FFFF);
        plan_item(OP_START, 32'h0000_0000);
        plan_item(OP_READ_DATA, 32'h0000_0000);
        plan_item(OP_READ_DATA, 32'h1234_5678);
        plan_item(OP_START, $urandom);
        answer_read(0);
        answer_read(0);
        plan_item(OP_START, 32'hFFFF_FFFF);
        answer_read(0);
        answer_read(1000);
        plan_item(OP_READ_DATA, 32'h0000_0000);
        wait_idle();

        // No idling, both registers at extremes: nothing is in range, so the address test
        // issues only its base writes. A whole passing test is queued and the receiver
        // holds off, so the result queue fills and the block stalls its input.
        configure(32'hFFFF_FFFF, 32'h0000_0000);
        run_test(200, 0, 0);
        @(posedge clk);
        hold_trigger <= ~hold_trigger;
        run_random_tests(30, 200, 15, 2);
        wait_idle();

        // The sender idles; a single offset, so the walk has nothing to check. Half way
        // through the sender pauses until every expected result has come back.
        set_idling(61, 0);
        configure(32'h0000_1000, 32'h0000_1005);
        run_random_tests(30, 200, 10, 2);
        pause_point = queued_items.size() / 2;
        while (queued_items.size() > pause_point)
            @(posedge clk);
        sender_paused <= 1'b1;
        @(posedge clk);
        while (item_valid || awaited_requests.size() != 0)
            @(posedge clk);
        sender_paused <= 1'b0;
        wait_idle();

        // The receiver stalls; three offsets.
        set_idling(0, 61);
        configure(32'h0004_0000, 32'h0004_0011);
        run_random_tests(30, 200, 10, 2);
        wait_idle();

        // Both sides idle; a base near the top of the address space, where a larger offset
        // would wrap and so must not be tested.
        set_idling(34, 34);
        configure(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        run_random_tests(30, 200, 10, 2);
        wait_idle();

        // No idling; the whole address space, so the offsets run up to the largest one.
        // The test is cut short by a fault once the walk has begun, then five offsets.
        set_idling(0, 0);
        configure(32'h0000_0000, 32'hFFFF_FFFF);
        run_test(100, 0, 0);
        wait_idle();
        configure(RESET_BASE, RESET_BASE + 32'h41);
        run_random_tests(30, 200, 8, 2);
        wait_idle();

        // Both sides idle again, with a fresh random setting for each short batch.
        set_idling(34, 34);
        for (int b = 0; b < 2; b++)
        begin
            pause_point = $urandom;
            configure(pause_point, pause_point + $urandom_range(0, 80));
            run_random_tests(25, 200, 10, 2);
            wait_idle();
        end

        if (error_count == 0)
            $display("tb_memory_bus_test_sequencer_unit: PASS");
        else
            $display("tb_memory_bus_test_sequencer_unit: FAIL");
        $finish;
    end

    // Stops a run that hangs, well beyond the slowest correct run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_memory_bus_test_sequencer_unit: FAIL");
        $finish;
    end

endmodule
